// ===== sv/mfx_pkg.sv =====
// Shared types and constants for the message fragmenter.
// No dependencies; imported by every module of the block.
package mfx_pkg;

    // Fragment header length in bytes
    localparam int unsigned HDR_BYTES   = 14;
    localparam int unsigned HDR_CNT_W   = $clog2(HDR_BYTES + 1);
    // Queue between the classifier and the byte emitter
    localparam int unsigned QUEUE_DEPTH = 4;

    // Fixed header bytes
    localparam logic [7:0] MAGIC_B     = 8'h42;
    localparam logic [7:0] MAGIC_C     = 8'h43;
    localparam logic [7:0] HDR_RSVD    = 8'h00;
    localparam logic [7:0] FLAG_SINGLE = 8'h00;
    localparam logic [7:0] FLAG_FRAG   = 8'h01;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAGS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VER   = 3'd5;

    localparam logic [7:0] MAX_FRAGS_RESET = 8'd255;
    localparam logic [7:0] FORMAT_VER_RESET = 8'd1;

    // One queued work entry: either a rejection or a payload byte that may
    // need a header in front of it
    typedef struct packed {
        logic        status;      // message rejected
        logic        hdr;         // emit a header before this byte
        logic [7:0]  data;        // scrambled payload byte
        logic [7:0]  frag_num;
        logic        last_frag;
        logic        last_msg;
        logic [15:0] msg_len;
        logic [31:0] msg_id;
        logic [7:0]  frag_total;
        logic        fragmented;
    } t_cmd;

endpackage

// ===== sv/mfx_front.sv =====
// Front end of the fragmenter: accepts message bytes, keeps message state,
// scrambles payload and produces queue entries. Depends on mfx_pkg.
module mfx_front
    import mfx_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         i_ready,
    input  logic [7:0]   i_data_byte,
    input  logic         i_first_of_message,
    input  logic [15:0]  i_message_length,
    input  logic [255:0] i_key,
    input  logic [7:0]   i_max_frags,
    output logic         o_push,
    output t_cmd         o_cmd
);

    localparam int unsigned PAYLOAD   = PACKET_BYTES - HDR_BYTES;
    localparam int unsigned DIV_SHIFT = 25;
    localparam int unsigned PROD_W    = 17 + DIV_SHIFT;
    localparam logic [DIV_SHIFT-1:0] DIV_MAGIC =
        DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'(PAYLOAD) - 64'd1) / 64'(PAYLOAD));
    localparam logic [16:0] PAY_M1  = 17'(PAYLOAD - 1);
    localparam logic [15:0] PAY_16  = 16'(PAYLOAD);
    localparam logic [8:0]  PAY_9   = 9'(PAYLOAD);

    logic [31:0] r_next_id, n_next_id;
    logic [31:0] r_cur_id, n_cur_id;
    logic [15:0] r_cur_len, n_cur_len;
    logic [15:0] r_bytes_done, n_bytes_done;
    logic [7:0]  r_bif, n_bif;
    logic [7:0]  r_frag_num, n_frag_num;
    logic [7:0]  r_frag_total, n_frag_total;
    logic        r_fragmented, n_fragmented;
    logic        r_dropping, n_dropping;

    logic              accept;
    logic [16:0]       div_in;
    logic [PROD_W-1:0] prod;
    logic [16:0]       frag_count;
    logic              too_many;
    logic              do_byte;
    logic [15:0]       e_len;
    logic [15:0]       e_done;
    logic [7:0]        e_bif;
    logic [7:0]        e_frag_num;
    logic [7:0]        e_total;
    logic              e_fragmented;
    logic [31:0]       e_id;
    logic              last_msg;
    logic              last_frag;

    assign accept = i_valid & i_ready;

    // Ceiling division by the payload size through an exact reciprocal
    assign div_in     = {1'b0, i_message_length} + PAY_M1;
    assign prod       = PROD_W'(div_in) * PROD_W'(DIV_MAGIC);
    assign frag_count = prod[PROD_W-1:DIV_SHIFT];
    assign too_many   = frag_count > {9'b0, i_max_frags};

    always_comb begin
        n_next_id    = r_next_id;
        n_cur_id     = r_cur_id;
        n_cur_len    = r_cur_len;
        n_bytes_done = r_bytes_done;
        n_bif        = r_bif;
        n_frag_num   = r_frag_num;
        n_frag_total = r_frag_total;
        n_fragmented = r_fragmented;
        n_dropping   = r_dropping;
        e_len        = r_cur_len;
        e_done       = r_bytes_done;
        e_bif        = r_bif;
        e_frag_num   = r_frag_num;
        e_total      = r_frag_total;
        e_fragmented = r_fragmented;
        e_id         = r_cur_id;
        do_byte      = 1'b0;
        last_msg     = 1'b0;
        last_frag    = 1'b0;
        o_push       = 1'b0;
        o_cmd        = '0;

        if (accept) begin
            if (i_first_of_message) begin
                // Abandon whatever was in progress
                n_dropping   = 1'b0;
                n_bytes_done = '0;
                n_bif        = '0;
                n_frag_num   = '0;
                n_cur_len    = i_message_length;
                e_len        = i_message_length;
                e_done       = '0;
                e_bif        = '0;
                e_frag_num   = '0;
                if (i_message_length == 16'd0) begin
                    n_dropping = 1'b1;
                end else if (too_many) begin
                    n_dropping   = 1'b1;
                    o_push       = 1'b1;
                    o_cmd.status = 1'b1;
                end else begin
                    n_frag_total = frag_count[7:0];
                    n_fragmented = i_message_length > PAY_16;
                    n_cur_id     = r_next_id;
                    n_next_id    = r_next_id + 32'd1;
                    e_total      = frag_count[7:0];
                    e_fragmented = i_message_length > PAY_16;
                    e_id         = r_next_id;
                    do_byte      = 1'b1;
                end
            end else if (!r_dropping && (r_bytes_done < r_cur_len)) begin
                do_byte = 1'b1;
            end
        end

        if (do_byte) begin
            last_msg  = ({1'b0, e_done} + 17'd1) == {1'b0, e_len};
            last_frag = last_msg || (({1'b0, e_bif} + 9'd1) == PAY_9);

            o_push           = 1'b1;
            o_cmd.hdr        = (e_bif == 8'd0);
            o_cmd.data       = i_data_byte ^ i_key[{e_bif[4:0], 3'b000} +: 8];
            o_cmd.frag_num   = e_frag_num;
            o_cmd.last_frag  = last_frag;
            o_cmd.last_msg   = last_msg;
            o_cmd.msg_len    = e_len;
            o_cmd.msg_id     = e_id;
            o_cmd.frag_total = e_total;
            o_cmd.fragmented = e_fragmented;

            n_bytes_done = e_done + 16'd1;
            if (last_frag) begin
                n_bif = '0;
                if (!last_msg) begin
                    n_frag_num = e_frag_num + 8'd1;
                end
            end else begin
                n_bif = e_bif + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id    <= 32'd1;
            r_cur_id     <= '0;
            r_cur_len    <= '0;
            r_bytes_done <= '0;
            r_bif        <= '0;
            r_frag_num   <= '0;
            r_frag_total <= '0;
            r_fragmented <= 1'b0;
            r_dropping   <= 1'b0;
        end else begin
            r_next_id    <= n_next_id;
            r_cur_id     <= n_cur_id;
            r_cur_len    <= n_cur_len;
            r_bytes_done <= n_bytes_done;
            r_bif        <= n_bif;
            r_frag_num   <= n_frag_num;
            r_frag_total <= n_frag_total;
            r_fragmented <= n_fragmented;
            r_dropping   <= n_dropping;
        end
    end

endmodule

// ===== sv/mfx_queue.sv =====
// Short FIFO of work entries between front end and byte emitter.
// Depends on mfx_pkg for the entry type and depth.
module mfx_queue
    import mfx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_cmd o_head
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full     = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_head     = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

endmodule

// ===== sv/mfx_back.sv =====
// Byte emitter: expands queued entries into header and payload bytes, or a
// status item for a rejection, and drives the output register. Depends on mfx_pkg.
module mfx_back
    import mfx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_nonempty,
    input  t_cmd       i_head,
    input  logic [7:0] i_format_version,
    input  logic       i_stall,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_is_header,
    output logic [7:0] o_fragment_index,
    output logic       o_last_in_fragment,
    output logic       o_last_in_message,
    output logic       o_status
);

    logic [HDR_CNT_W-1:0] r_hdr_cnt;
    logic                 r_valid;
    logic [7:0]           r_byte;
    logic                 r_is_hdr;
    logic [7:0]           r_frag_idx;
    logic                 r_last_frag;
    logic                 r_last_msg;
    logic                 r_status;

    logic       advance;
    logic       in_hdr;
    logic [7:0] hdr_tab [HDR_BYTES];

    assign advance = !r_valid || !i_stall;
    assign in_hdr  = i_head.hdr && (r_hdr_cnt != HDR_CNT_W'(HDR_BYTES));
    assign o_pop   = advance && i_nonempty && !in_hdr;

    always_comb begin
        hdr_tab[0]  = MAGIC_B;
        hdr_tab[1]  = MAGIC_C;
        hdr_tab[2]  = HDR_RSVD;
        hdr_tab[3]  = HDR_RSVD;
        hdr_tab[4]  = i_format_version;
        hdr_tab[5]  = i_head.fragmented ? FLAG_FRAG : FLAG_SINGLE;
        hdr_tab[6]  = i_head.msg_len[15:8];
        hdr_tab[7]  = i_head.msg_len[7:0];
        hdr_tab[8]  = i_head.msg_id[31:24];
        hdr_tab[9]  = i_head.msg_id[23:16];
        hdr_tab[10] = i_head.msg_id[15:8];
        hdr_tab[11] = i_head.msg_id[7:0];
        hdr_tab[12] = i_head.frag_num;
        hdr_tab[13] = i_head.frag_total;
    end

    // Header counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_hdr_cnt <= '0;
        end else if (advance) begin
            r_valid <= i_nonempty;
            if (i_nonempty) begin
                r_hdr_cnt <= in_hdr ? r_hdr_cnt + HDR_CNT_W'(1) : '0;
            end
        end
    end

    // Output payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (advance && i_nonempty) begin
            if (in_hdr) begin
                r_byte      <= hdr_tab[r_hdr_cnt];
                r_is_hdr    <= 1'b1;
                r_frag_idx  <= i_head.frag_num;
                r_last_frag <= 1'b0;
                r_last_msg  <= 1'b0;
                r_status    <= 1'b0;
            end else if (i_head.status) begin
                r_byte      <= '0;
                r_is_hdr    <= 1'b0;
                r_frag_idx  <= '0;
                r_last_frag <= 1'b0;
                r_last_msg  <= 1'b0;
                r_status    <= 1'b1;
            end else begin
                r_byte      <= i_head.data;
                r_is_hdr    <= 1'b0;
                r_frag_idx  <= i_head.frag_num;
                r_last_frag <= i_head.last_frag;
                r_last_msg  <= i_head.last_msg;
                r_status    <= 1'b0;
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_out_byte         = r_byte;
    assign o_is_header        = r_is_hdr;
    assign o_fragment_index   = r_frag_idx;
    assign o_last_in_fragment = r_last_frag;
    assign o_last_in_message  = r_last_msg;
    assign o_status           = r_status;

endmodule

// ===== sv/message_fragmenter_xor_core.sv =====
// Message fragmenter top level: configuration registers, front end, queue
// and byte emitter. Depends on mfx_pkg, mfx_front, mfx_queue and mfx_back.
//
// Takes a serialised message one byte per item and emits it as fragments of
// up to PACKET_BYTES-14 payload bytes, each led by a 14-byte header (magic
// 'B' 'C', two reserved zero bytes, format version, flags, big-endian
// length, big-endian 32-bit message id, fragment number, fragment total).
// Payload bytes are XORed with the 32-byte key, restarting at key byte 0 in
// every fragment. A message needing more fragments than max_fragments gives
// a single item with status set and consumes no id; its remaining bytes are
// dropped. Rate: the output side delivers one item per cycle while it is not
// stalled and has work queued. An input item that does not open a fragment
// gives one output item; one that opens a fragment gives fifteen (fourteen
// header bytes, then its payload byte), so the input side stalls once the
// four-entry work queue has filled. An accepted item passes through the
// work queue and then the output register. The first byte of a message
// goes through one constant-reciprocal multiplier that counts the
// fragments. Keep configuration writes to idle periods; the key and
// version are read while items are in flight.
module message_fragmenter_xor_core
    import mfx_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    // Input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_first_of_message,
    input  logic [15:0]          i_message_length,
    // Output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_is_header,
    output logic [7:0]           o_fragment_index,
    output logic                 o_last_in_fragment,
    output logic                 o_last_in_message,
    output logic                 o_status
);

    logic [63:0] r_key_word_0;
    logic [63:0] r_key_word_1;
    logic [63:0] r_key_word_2;
    logic [63:0] r_key_word_3;
    logic [7:0]  r_max_frags;
    logic [7:0]  r_format_ver;

    logic q_full;
    logic q_nonempty;
    logic q_push;
    logic q_pop;
    t_cmd q_in;
    t_cmd q_head;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_word_0 <= '0;
            r_key_word_1 <= '0;
            r_key_word_2 <= '0;
            r_key_word_3 <= '0;
            r_max_frags  <= MAX_FRAGS_RESET;
            r_format_ver <= FORMAT_VER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_WORD_0: r_key_word_0 <= i_cfg_data;
                CFG_KEY_WORD_1: r_key_word_1 <= i_cfg_data;
                CFG_KEY_WORD_2: r_key_word_2 <= i_cfg_data;
                CFG_KEY_WORD_3: r_key_word_3 <= i_cfg_data;
                CFG_MAX_FRAGS:  r_max_frags  <= i_cfg_data[7:0];
                CFG_FORMAT_VER: r_format_ver <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Stall input only when the work queue is full
    assign o_in_stall = q_full;

    mfx_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .i_ready            (!q_full),
        .i_data_byte        (i_data_byte),
        .i_first_of_message (i_first_of_message),
        .i_message_length   (i_message_length),
        .i_key              ({r_key_word_3, r_key_word_2, r_key_word_1, r_key_word_0}),
        .i_max_frags        (r_max_frags),
        .o_push             (q_push),
        .o_cmd              (q_in)
    );

    mfx_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_cmd      (q_in),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    mfx_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_nonempty         (q_nonempty),
        .i_head             (q_head),
        .i_format_version   (r_format_ver),
        .i_stall            (i_out_stall),
        .o_pop              (q_pop),
        .o_valid            (o_out_valid),
        .o_out_byte         (o_out_byte),
        .o_is_header        (o_is_header),
        .o_fragment_index   (o_fragment_index),
        .o_last_in_fragment (o_last_in_fragment),
        .o_last_in_message  (o_last_in_message),
        .o_status           (o_status)
    );

endmodule

// ===== tb/message_fragmenter_xor_checker.sv =====
`timescale 1ns / 100ps
// Checker for the message fragmenter: watches the register port and both
// channels, predicts every output item and compares. Depends on mfx_pkg.
module message_fragmenter_xor_checker
    import mfx_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_first_of_message,
    input  logic [15:0]          i_message_length,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [7:0]           i_out_byte,
    input  logic                 i_is_header,
    input  logic [7:0]           i_fragment_index,
    input  logic                 i_last_in_fragment,
    input  logic                 i_last_in_message,
    input  logic                 i_status,
    output int                   o_pending,
    output int                   o_fail_count
);

    localparam int unsigned PAYLOAD_BYTES = PACKET_BYTES - HDR_BYTES;

    typedef struct packed {
        logic [7:0] value;
        logic       header;
        logic [7:0] frag;
        logic       frag_end;
        logic       msg_end;
        logic       rejected;
    } t_frag_byte;

    t_frag_byte expected_bytes[$];

    // Register copies
    logic [63:0] key_words [4];
    logic [7:0]  frag_limit;
    logic [7:0]  version_byte;

    // Fragmenter state
    logic [31:0] id_next;
    logic [31:0] id_now;
    logic [15:0] msg_len;
    logic [15:0] done_cnt;
    logic [7:0]  frag_fill;
    logic [7:0]  frag_num;
    logic [7:0]  frag_total;
    logic        multi_frag;
    logic        discarding;

    function automatic logic [7:0] key_at(input logic [7:0] pos);
        logic [4:0] k;
        k = pos[4:0];
        return key_words[k[4:3]][k[2:0]*8 +: 8];
    endfunction

    task automatic push_byte(input logic [7:0] v, input logic h, input logic [7:0] f,
                             input logic fe, input logic me, input logic rj);
        t_frag_byte b;
        b.value    = v;
        b.header   = h;
        b.frag     = f;
        b.frag_end = fe;
        b.msg_end  = me;
        b.rejected = rj;
        expected_bytes.push_back(b);
    endtask

    task automatic fragment_item(input logic [7:0] data, input logic first,
                                 input logic [15:0] len);
        logic [31:0] count;
        logic [7:0]  hdr [HDR_BYTES];
        logic        last_msg;
        logic        last_frag;
        if (first) begin
            discarding = 1'b0;
            done_cnt   = '0;
            frag_fill  = '0;
            frag_num   = '0;
            msg_len    = len;
            if (len == 16'd0) begin
                discarding = 1'b1;
                return;
            end
            count = (32'(len) + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
            if (count > 32'(frag_limit)) begin
                discarding = 1'b1;
                push_byte(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
                return;
            end
            frag_total = count[7:0];
            multi_frag = 32'(len) > PAYLOAD_BYTES;
            id_now     = id_next;
            id_next    = id_next + 32'd1;
        end else if (discarding || done_cnt >= msg_len) begin
            return;
        end

        if (frag_fill == 8'd0) begin
            hdr[0]  = MAGIC_B;
            hdr[1]  = MAGIC_C;
            hdr[2]  = HDR_RSVD;
            hdr[3]  = HDR_RSVD;
            hdr[4]  = version_byte;
            hdr[5]  = multi_frag ? FLAG_FRAG : FLAG_SINGLE;
            hdr[6]  = msg_len[15:8];
            hdr[7]  = msg_len[7:0];
            hdr[8]  = id_now[31:24];
            hdr[9]  = id_now[23:16];
            hdr[10] = id_now[15:8];
            hdr[11] = id_now[7:0];
            hdr[12] = frag_num;
            hdr[13] = frag_total;
            for (int i = 0; i < HDR_BYTES; i++)
                push_byte(hdr[i], 1'b1, frag_num, 1'b0, 1'b0, 1'b0);
        end

        last_msg  = (32'(done_cnt) + 1) == 32'(msg_len);
        last_frag = last_msg || ((32'(frag_fill) + 1) == PAYLOAD_BYTES);
        push_byte(data ^ key_at(frag_fill), 1'b0, frag_num, last_frag, last_msg, 1'b0);
        done_cnt = done_cnt + 16'd1;
        if (last_frag) begin
            frag_fill = '0;
            if (!last_msg) frag_num = frag_num + 8'd1;
        end else begin
            frag_fill = frag_fill + 8'd1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_frag_byte want;
        if (!i_rst_n) begin
            for (int w = 0; w < 4; w++) key_words[w] = '0;
            frag_limit   = MAX_FRAGS_RESET;
            version_byte = FORMAT_VER_RESET;
            id_next      = 32'd1;
            id_now       = '0;
            msg_len      = '0;
            done_cnt     = '0;
            frag_fill    = '0;
            frag_num     = '0;
            frag_total   = '0;
            multi_frag   = 1'b0;
            discarding   = 1'b0;
            expected_bytes.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_WORD_0: key_words[0] = i_cfg_data;
                    CFG_KEY_WORD_1: key_words[1] = i_cfg_data;
                    CFG_KEY_WORD_2: key_words[2] = i_cfg_data;
                    CFG_KEY_WORD_3: key_words[3] = i_cfg_data;
                    CFG_MAX_FRAGS:  frag_limit   = i_cfg_data[7:0];
                    CFG_FORMAT_VER: version_byte = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                fragment_item(i_data_byte, i_first_of_message, i_message_length);
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("output item with nothing pending, out_byte",
                                    32'(i_out_byte), 32'd0);
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_byte != want.value)
                        report_mismatch("out_byte", 32'(i_out_byte), 32'(want.value));
                    if (i_is_header != want.header)
                        report_mismatch("is_header", 32'(i_is_header), 32'(want.header));
                    if (i_fragment_index != want.frag)
                        report_mismatch("fragment_index", 32'(i_fragment_index),
                                        32'(want.frag));
                    if (i_last_in_fragment != want.frag_end)
                        report_mismatch("last_in_fragment", 32'(i_last_in_fragment),
                                        32'(want.frag_end));
                    if (i_last_in_message != want.msg_end)
                        report_mismatch("last_in_message", 32'(i_last_in_message),
                                        32'(want.msg_end));
                    if (i_status != want.rejected)
                        report_mismatch("status", 32'(i_status), 32'(want.rejected));
                end
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

// ===== tb/message_fragmenter_xor_core_test.sv =====
`timescale 1ns / 100ps
// Top of the message fragmenter test: clock, reset, stimulus and verdict.
// Depends on mfx_pkg, message_fragmenter_xor_core and the checker module.
module message_fragmenter_xor_core_test
    import mfx_pkg::*;
();

    localparam int unsigned PKT_BYTES     = 128;
    localparam int unsigned PAYLOAD       = PKT_BYTES - HDR_BYTES;
    // Random items after the directed ones; about 460 items in all
    localparam int unsigned RANDOM_ITEMS  = 436;
    // Queue of four, each entry up to fifteen output items, plus margin
    localparam int unsigned SETTLE_CYCLES = 80;
    // Final stretch of the random part runs with no idling on either side
    localparam int unsigned QUIET_TAIL    = 90;
    localparam int unsigned ROUND_ITEMS   = 50;

    // Register indexes the block does not use
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    logic                 clk              = 1'b0;
    logic                 rst_n            = 1'b0;
    logic                 cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx          = '0;
    logic [63:0]          cfg_data         = '0;
    logic                 in_valid         = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte        = '0;
    logic                 first_of_message = 1'b0;
    logic [15:0]          message_length   = '0;
    logic                 out_valid;
    logic                 out_stall        = 1'b0;
    logic [7:0]           out_byte;
    logic                 is_header;
    logic [7:0]           fragment_index;
    logic                 last_in_fragment;
    logic                 last_in_message;
    logic                 status;

    int pending;
    int fail_count;
    int items_sent  = 0;
    int stall_left  = 0;
    bit tx_gaps     = 1'b0;
    bit rx_stalls   = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    message_fragmenter_xor_core #(
        .PACKET_BYTES (PKT_BYTES)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_data_byte        (data_byte),
        .i_first_of_message (first_of_message),
        .i_message_length   (message_length),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_out_byte         (out_byte),
        .o_is_header        (is_header),
        .o_fragment_index   (fragment_index),
        .o_last_in_fragment (last_in_fragment),
        .o_last_in_message  (last_in_message),
        .o_status           (status)
    );

    message_fragmenter_xor_checker #(
        .PACKET_BYTES (PKT_BYTES)
    ) checker_i (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_data_byte        (data_byte),
        .i_first_of_message (first_of_message),
        .i_message_length   (message_length),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_out_byte         (out_byte),
        .i_is_header        (is_header),
        .i_fragment_index   (fragment_index),
        .i_last_in_fragment (last_in_fragment),
        .i_last_in_message  (last_in_message),
        .i_status           (status),
        .o_pending          (pending),
        .o_fail_count       (fail_count)
    );

    // Watchdog: several times the slowest legal run
    initial begin
        #(600000 * 12);
        $display("Mismatches found");
        $finish;
    end

    // Receiver back-pressure: stall bursts started at random, their length drawn at random into stall_left
    always @(posedge clk) begin
        if (!rx_stalls) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end else begin
            out_stall  <= 1'b0;
        end
    end

    // Offer one item, optionally after a gap, and hold it until accepted.
    // Called and returns at a rising edge.
    task automatic send_item(input logic [7:0] d, input logic f, input logic [15:0] l);
        int gap;
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        data_byte        <= d;
        first_of_message <= f;
        message_length   <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // Send the first byte of a message and then nbytes-1 further bytes;
    // the length field of the later bytes is noise the block must ignore
    task automatic send_message(input logic [15:0] len, input int nbytes);
        send_item(8'($urandom), 1'b1, len);
        for (int i = 1; i < nbytes; i++)
            send_item(8'($urandom), 1'b0, 16'($urandom));
    endtask

    // Drop valid and wait until every predicted output item has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Drain, then let the block idle before the next step
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Keep cfg_we high across back-to-back writes; the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge clk);
    endtask

    // Write every register; the 8-bit ones get random upper bits to show
    // that only the low byte counts
    task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [7:0] maxf, input logic [7:0] ver);
        logic [63:0] wide;
        write_reg(CFG_KEY_WORD_0, k0);
        write_reg(CFG_KEY_WORD_1, k1);
        write_reg(CFG_KEY_WORD_2, k2);
        write_reg(CFG_KEY_WORD_3, k3);
        wide = {$urandom, $urandom};
        wide[7:0] = maxf;
        write_reg(CFG_MAX_FRAGS, wide);
        wide = {$urandom, $urandom};
        wide[7:0] = ver;
        write_reg(CFG_FORMAT_VER, wide);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return 64'd0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [7:0] pick_max_frags();
        case ($urandom_range(0, 6))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd3;
            4:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_version();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // One random message: mostly short and complete, some medium, some on the fragment
    // boundaries, some abandoned early, huge ones cut short, a few empty.
    // Room caps the bytes sent so the run ends near its item count.
    task automatic random_message(input int room);
        logic [15:0] len;
        int          r;
        int          nbytes;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            len = 16'($urandom_range(1, 24));
        end else if (r < 63) begin
            case ($urandom_range(0, 4))
                0:       len = 16'(PAYLOAD - 1);
                1:       len = 16'(PAYLOAD);
                2:       len = 16'(PAYLOAD + 1);
                3:       len = 16'(2 * PAYLOAD);
                default: len = 16'(2 * PAYLOAD + 1);
            endcase
        end else if (r < 78) begin
            len = 16'($urandom_range(25, 260));
        end else if (r < 93) begin
            len = 16'($urandom);
        end else begin
            len = 16'd0;
        end

        if (len == 16'd0)
            nbytes = $urandom_range(1, 4);
        else if (len > 16'd300)
            nbytes = $urandom_range(1, 6);
        else if ($urandom_range(0, 9) == 0)
            nbytes = $urandom_range(1, len);
        else
            nbytes = len;
        if (nbytes > room)
            nbytes = (room < 1) ? 1 : room;

        // Now and then hold the sender back until the output has caught up
        if ($urandom_range(0, 19) == 0) wait_drained();
        send_message(len, nbytes);

        // Stray bytes after the message: ignored once it is complete
        if ($urandom_range(0, 11) == 0) begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
                send_item(8'($urandom), 1'b0, 16'($urandom));
        end
    endtask

    initial begin : stimulus
        int directed_end;
        int round_end;
        int round;
        bit quiet;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_gaps = 1'b1;
        rx_stalls <= 1'b1;

        // Directed part, registers at their reset values.
        // Bytes while idle: drop without output
        send_item(8'hFF, 1'b0, 16'hFFFF);
        send_item(8'h00, 1'b0, 16'h0000);
        // Zero length: no output, the next byte is dropped
        send_message(16'd0, 2);
        // Shortest messages, data extremes
        send_item(8'hFF, 1'b1, 16'd1);
        send_item(8'h00, 1'b1, 16'd2);
        send_item(8'hA5, 1'b0, 16'd2);
        // Far too many fragments: one rejection item, rest dropped
        send_message(16'hFFFF, 3);
        // Exactly max_fragments fragments: accepted, then abandoned by
        // a new message arriving while busy
        send_message(16'(255 * PAYLOAD), 3);
        send_message(16'd3, 3);
        send_item(8'h5A, 1'b0, 16'h1234);

        // Zero max_fragments rejects everything
        settle();
        write_reg(CFG_MAX_FRAGS, 64'd0);
        cfg_we <= 1'b0;
        send_message(16'd1, 1);
        send_message(16'd5, 2);

        // Spare indexes change nothing; a single fragment allowed
        settle();
        write_reg(CFG_SPARE_6, {$urandom, $urandom});
        write_reg(CFG_SPARE_7, {$urandom, $urandom});
        write_reg(CFG_MAX_FRAGS, 64'd1);
        cfg_we <= 1'b0;
        send_message(16'(PAYLOAD + 1), 2);
        send_message(16'd2, 2);
        directed_end = items_sent;

        // Random part in rounds, each with its own register setting
        round = 0;
        while (items_sent < directed_end + RANDOM_ITEMS) begin
            settle();
            case (round)
                0:       write_all('1, '1, '1, '1, 8'd255, 8'd255);
                1:       write_all(64'd0, 64'd0, 64'd0, 64'd0, 8'd2, 8'd0);
                default: write_all(pick_key(), pick_key(), pick_key(), pick_key(),
                                   pick_max_frags(), pick_version());
            endcase
            quiet = items_sent + QUIET_TAIL >= directed_end + RANDOM_ITEMS;
            tx_gaps = !quiet && $urandom_range(0, 3) != 0;
            rx_stalls <= !quiet && $urandom_range(0, 3) != 0;
            round_end = items_sent + ROUND_ITEMS;
            while (items_sent < round_end && items_sent < directed_end + RANDOM_ITEMS) begin
                if (!quiet && items_sent + QUIET_TAIL >= directed_end + RANDOM_ITEMS) begin
                    quiet = 1'b1;
                    tx_gaps = 1'b0;
                    rx_stalls <= 1'b0;
                end
                random_message(directed_end + RANDOM_ITEMS - items_sent);
            end
            round++;
        end

        // Wind down: no stalls, drain, let the pipe go quiet, then judge
        tx_gaps = 1'b0;
        rx_stalls <= 1'b0;
        settle();
        @(negedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== message_fragmenter_xor_core.f =====
sv/mfx_pkg.sv
sv/mfx_front.sv
sv/mfx_queue.sv
sv/mfx_back.sv
sv/message_fragmenter_xor_core.sv
tb/message_fragmenter_xor_checker.sv
tb/message_fragmenter_xor_core_test.sv
